/* src/standing_wave_displacement_macros.svh */
// assertion macros for the standing wave displacement block
// expects a clock named clk and an active high reset named rst in scope
`ifndef STANDING_WAVE_DISPLACEMENT_MACROS_SVH
`define STANDING_WAVE_DISPLACEMENT_MACROS_SVH

// same-cycle implication
`define SWD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("standing wave displacement check failed");

// next-cycle implication
`define SWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("standing wave displacement check failed");

`endif

/* src/swd_pkg.sv */
// shared types, constants and the cordic angle table
// used by every module of the standing wave displacement block
package swd_pkg;

  // one input word
  typedef struct packed {
    logic [15:0] position;
    logic [31:0] sample_time;
    logic [7:0]  harmonic;
  } swd_in_t;

  // one result word
  typedef struct packed {
    logic signed [15:0] displacement;
    logic               bad_mode;
  } swd_out_t;

  // control that travels with each word through the pipeline
  typedef struct packed {
    logic valid;
    logic bad;
  } swd_ctl_t;

  // register indexes on the config port
  localparam logic [1:0] REG_AMPLITUDE     = 2'd0;
  localparam logic [1:0] REG_SPATIAL_RATE  = 2'd1;
  localparam logic [1:0] REG_TEMPORAL_RATE = 2'd2;

  localparam logic signed [15:0] AMPLITUDE_RST     = 16'sd16384;
  localparam logic [31:0]        SPATIAL_RATE_RST  = 32'd32768;
  localparam logic [31:0]        TEMPORAL_RATE_RST = 32'd65536;

  // cordic datapath widths: x and y in q2.30 with headroom, angle in turns
  localparam int CW = 34;
  localparam int ZW = 33;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

  // atan(2^-i) in q0.32 turns
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517C;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A2F;
      19: v = 32'h00000517;
      20: v = 32'h0000028B;
      21: v = 32'h00000145;
      22: v = 32'h000000A2;
      23: v = 32'h00000051;
      24: v = 32'h00000028;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000002;
      29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* src/standing_wave_displacement.sv */
// standing wave displacement: A*sin(phase_s)*cos(phase_t) in q1.15
// depends on swd_pkg, swd_phase, swd_cordic, swd_scale and the macros header
//
//  channel   handshake                  payload
//  input     start, busy (always low)   item   (swd_in_t)
//  result    done strobe, one cycle     result (swd_out_t)
//  config    apb psel/penable/pwrite    paddr, pwdata, prdata
//
// one word accepted every cycle; the pipeline registers hold the two phase
// multiplies, one cordic register per rotation, the quadrant fold, the two
// scaling multiplies and saturation. reset is synchronous and clears the config
// and control registers only; the result side has no backpressure.
`include "standing_wave_displacement_macros.svh"

module standing_wave_displacement
  import swd_pkg::*;
#(
  parameter int CORDIC_STAGES = 16,
  parameter int PHASE_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  swd_in_t     item,
  output logic        done,
  output swd_out_t    result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LATENCY = CORDIC_STAGES + 6;

  logic signed [15:0] amplitude;
  logic [31:0]        spatial_rate;
  logic [31:0]        temporal_rate;
  logic [1:0]         reg_idx;
  logic               wr_en;

  swd_ctl_t           ctl_in, ctl_ph, ctl_cd;
  logic [31:0]        phase_s, phase_t;
  logic signed [31:0] sin_s, cos_t;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude     <= AMPLITUDE_RST;
      spatial_rate  <= SPATIAL_RATE_RST;
      temporal_rate <= TEMPORAL_RATE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_AMPLITUDE:     amplitude     <= pwdata[15:0];
        REG_SPATIAL_RATE:  spatial_rate  <= pwdata;
        REG_TEMPORAL_RATE: temporal_rate <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_AMPLITUDE:     prdata = {{16{amplitude[15]}}, amplitude};
      REG_SPATIAL_RATE:  prdata = spatial_rate;
      REG_TEMPORAL_RATE: prdata = temporal_rate;
      default:           prdata = '0;
    endcase
  end

  // input word control
  assign ctl_in.valid = start & ~busy;
  assign ctl_in.bad   = (item.harmonic == 8'd0);

  swd_phase u_phase (
    .clk           (clk),
    .rst           (rst),
    .word          (item),
    .ctl_in        (ctl_in),
    .spatial_rate  (spatial_rate),
    .temporal_rate (temporal_rate),
    .phase_s       (phase_s),
    .phase_t       (phase_t),
    .ctl_out       (ctl_ph)
  );

  swd_cordic #(
    .STAGES     (CORDIC_STAGES),
    .PHASE_BITS (PHASE_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .phase_s (phase_s),
    .phase_t (phase_t),
    .ctl_in  (ctl_ph),
    .sin_s   (sin_s),
    .cos_t   (cos_t),
    .ctl_out (ctl_cd)
  );

  swd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sin_s     (sin_s),
    .cos_t     (cos_t),
    .ctl_in    (ctl_cd),
    .amplitude (amplitude),
    .result    (result),
    .done      (done)
  );

  // checks
  `SWD_ASSERT_NOW(a_bad_zero, done && result.bad_mode, result.displacement == 16'sd0)
  `SWD_ASSERT_NOW(a_latency, start && !busy, ##LATENCY done)
  `SWD_ASSERT_NOW(a_bad_flag, start && !busy && item.harmonic == 8'd0, ##LATENCY (done && result.bad_mode))

endmodule

/* src/swd_phase.sv */
// phase generation: harmonic times position and time, then times the rates
// depends on swd_pkg
module swd_phase
  import swd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  swd_in_t     word,
  input  swd_ctl_t    ctl_in,
  input  logic [31:0] spatial_rate,
  input  logic [31:0] temporal_rate,
  output logic [31:0] phase_s,
  output logic [31:0] phase_t,
  output swd_ctl_t    ctl_out
);

  logic [23:0] nx;
  logic [31:0] nt;
  swd_ctl_t    ctl_a;
  logic [39:0] nt_full;
  logic [55:0] ps_full;
  logic [63:0] pt_full;

  assign nt_full = word.harmonic * word.sample_time;
  assign ps_full = nx * spatial_rate;
  assign pt_full = nt * temporal_rate;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a   <= '0;
      ctl_out <= '0;
    end else begin
      ctl_a.valid <= ctl_in.valid;
      ctl_a.bad   <= ctl_in.bad;
      ctl_out     <= ctl_a;
    end
  end

  // first stage: harmonic products, second stage: rate products mod 2^32
  always_ff @(posedge clk) begin
    nx      <= word.harmonic * word.position;
    nt      <= nt_full[31:0];
    phase_s <= ps_full[31:0];
    phase_t <= pt_full[31:0];
  end

endmodule

/* src/swd_cordic.sv */
// two-lane pipelined cordic rotator: sine of lane s, cosine of lane t
// depends on swd_pkg
module swd_cordic
  import swd_pkg::*;
#(
  parameter int STAGES     = 16,
  parameter int PHASE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        phase_s,
  input  logic [31:0]        phase_t,
  input  swd_ctl_t           ctl_in,
  output logic signed [31:0] sin_s,
  output logic signed [31:0] cos_t,
  output swd_ctl_t           ctl_out
);

  localparam int DROP = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam logic [31:0] MASK = 32'hFFFF_FFFF << DROP;

  logic signed [CW-1:0] xs [2][STAGES+1];
  logic signed [CW-1:0] ys [2][STAGES+1];
  logic signed [ZW-1:0] zs [2][STAGES+1];
  logic [1:0]           qs [2][STAGES+1];
  swd_ctl_t             cs [STAGES+1];
  logic [31:0]          ph [2];

  assign ph[0] = phase_s & MASK;
  assign ph[1] = phase_t & MASK;
  assign cs[0] = ctl_in;

  // stage zero seed
  for (genvar l = 0; l < 2; l++) begin : g_seed
    assign xs[l][0] = CORDIC_INV_GAIN;
    assign ys[l][0] = '0;
    assign zs[l][0] = {3'b000, ph[l][29:0]};
    assign qs[l][0] = ph[l][31:30];
  end

  // rotation stages, one register each
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        cs[i+1] <= '0;
      end else begin
        cs[i+1] <= cs[i];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [ZW-1:0] at;
      assign at = {1'b0, atan_turn(i)};
      always_ff @(posedge clk) begin
        qs[l][i+1] <= qs[l][i];
        if (!zs[l][i][ZW-1]) begin
          xs[l][i+1] <= xs[l][i] - (ys[l][i] >>> i);
          ys[l][i+1] <= ys[l][i] + (xs[l][i] >>> i);
          zs[l][i+1] <= zs[l][i] - at;
        end else begin
          xs[l][i+1] <= xs[l][i] + (ys[l][i] >>> i);
          ys[l][i+1] <= ys[l][i] - (xs[l][i] >>> i);
          zs[l][i+1] <= zs[l][i] + at;
        end
      end
    end
  end

  // quadrant fold
  logic signed [CW-1:0] s_sel, c_sel;
  always_comb begin
    case (qs[0][STAGES])
      2'd0:    s_sel = ys[0][STAGES];
      2'd1:    s_sel = xs[0][STAGES];
      2'd2:    s_sel = -ys[0][STAGES];
      default: s_sel = -xs[0][STAGES];
    endcase
    case (qs[1][STAGES])
      2'd0:    c_sel = xs[1][STAGES];
      2'd1:    c_sel = -ys[1][STAGES];
      2'd2:    c_sel = -xs[1][STAGES];
      default: c_sel = ys[1][STAGES];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= cs[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    sin_s <= s_sel[31:0];
    cos_t <= c_sel[31:0];
  end

endmodule

/* src/swd_scale.sv */
// product of sine and cosine, amplitude scaling, rounding and saturation
// depends on swd_pkg
module swd_scale
  import swd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] sin_s,
  input  logic signed [31:0] cos_t,
  input  swd_ctl_t           ctl_in,
  input  logic signed [15:0] amplitude,
  output swd_out_t           result,
  output logic               done
);

  localparam logic signed [63:0] HALF64 = 64'sd536870912;
  localparam logic signed [49:0] HALF50 = 50'sd536870912;

  logic signed [63:0] sc_full, sc_rnd;
  logic signed [33:0] prod;
  logic signed [49:0] m_full, m_rnd;
  logic signed [19:0] yv;
  swd_ctl_t           ctl_p, ctl_y;
  logic signed [15:0] sat;

  assign sc_full = sin_s * cos_t;
  assign sc_rnd  = (sc_full + HALF64) >>> 30;
  assign m_full  = amplitude * prod;
  assign m_rnd   = (m_full + HALF50) >>> 30;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p <= '0;
      ctl_y <= '0;
      done  <= 1'b0;
    end else begin
      ctl_p <= ctl_in;
      ctl_y <= ctl_p;
      done  <= ctl_y.valid;
    end
  end

  // saturate to q1.15
  always_comb begin
    if (yv > 20'sd32767) begin
      sat = 16'sh7FFF;
    end else if (yv < -20'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = yv[15:0];
    end
  end

  always_ff @(posedge clk) begin
    prod                <= sc_rnd[33:0];
    yv                  <= m_rnd[19:0];
    result.displacement <= ctl_y.bad ? 16'sd0 : sat;
    result.bad_mode     <= ctl_y.bad;
  end

endmodule

/* tb/standing_wave_displacement_test.sv */
// self-checking testbench for the standing wave displacement block
// depends on swd_pkg and standing_wave_displacement; drives apb config and command port
module standing_wave_displacement_test;
  import swd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 22;
  localparam int STAGES = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1000;

  // atan(2^-i) in q0.32 turns, rotation stages only
  localparam longint ROT_ANGLE [STAGES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  swd_in_t item = '0;
  logic done;
  swd_out_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor copy of the registers
  logic signed [15:0] amp_reg = AMPLITUDE_RST;
  logic [31:0] xrate_reg = SPATIAL_RATE_RST;
  logic [31:0] trate_reg = TEMPORAL_RATE_RST;

  swd_out_t pending_points[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int bad_modes_seen = 0;
  int cycles = 0;

  standing_wave_displacement uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // cos and sin of a turn phase, q2.30
  function automatic void turn_sincos(input logic [31:0] ph, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ROT_ANGLE[i];
      end else begin
        x += dx; y -= dy; z += ROT_ANGLE[i];
      end
    end
    case (ph[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic swd_out_t wave_point(input swd_in_t w);
    swd_out_t r;
    logic [63:0] mx, mt;
    longint cs, ss, ct, st, prod, yv;
    r = '0;
    if (w.harmonic == 0) begin
      r.bad_mode = 1'b1;
      return r;
    end
    mx = 64'(w.harmonic) * 64'(w.position) * 64'(xrate_reg);
    mt = 64'(w.harmonic) * 64'(w.sample_time) * 64'(trate_reg);
    turn_sincos(mx[31:0], cs, ss);
    turn_sincos(mt[31:0], ct, st);
    prod = (ss * ct + (64'sd1 <<< 29)) >>> 30;
    yv = (longint'(amp_reg) * prod + (64'sd1 <<< 29)) >>> 30;
    if (yv > 32767) yv = 32767;
    if (yv < -32768) yv = -32768;
    r.displacement = 16'(yv);
    return r;
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("standing_wave_displacement: mismatch");
      $finish;
    end
  end

  // register writes seen on the config port
  always @(posedge clk) begin
    if (!rst && psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_AMPLITUDE:     amp_reg <= pwdata[15:0];
        REG_SPATIAL_RATE:  xrate_reg <= pwdata;
        REG_TEMPORAL_RATE: trate_reg <= pwdata;
        default: ;
      endcase
    end
  end

  // accepted words become expectations
  always @(posedge clk) begin
    if (!rst && start && !busy) pending_points.push_back(wave_point(item));
  end

  // result words against the oldest expectation
  always @(posedge clk) begin
    swd_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (result.bad_mode) bad_modes_seen++;
      if (pending_points.size() == 0) begin
        report("unexpected word", result.displacement, 0);
      end else begin
        want = pending_points.pop_front();
        if (result.displacement !== want.displacement)
          report("displacement", result.displacement, want.displacement);
        if (result.bad_mode !== want.bad_mode)
          report("bad_mode", result.bad_mode, want.bad_mode);
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // read back and compare the meaningful bits
  task automatic apb_check(input logic [1:0] idx, input logic [31:0] want, input int bits);
    logic [31:0] mask;
    mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if ((prdata & mask) !== (want & mask)) report("register readback", prdata & mask, want & mask);
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] a, input logic [31:0] xs, input logic [31:0] ts);
    apb_write(REG_AMPLITUDE, {16'h0, a});
    apb_write(REG_SPATIAL_RATE, xs);
    apb_write(REG_TEMPORAL_RATE, ts);
    apb_check(REG_AMPLITUDE, {16'h0, a}, 16);
    apb_check(REG_SPATIAL_RATE, xs, 32);
    apb_check(REG_TEMPORAL_RATE, ts, 32);
  endtask

  // wait until every result is back, then let the pipeline drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // hold one word until it is taken; start stays high across words
  task automatic send_word(input swd_in_t w);
    logic taken;
    item <= w;
    start <= 1'b1;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    words_sent++;
  endtask

  function automatic swd_in_t random_point();
    swd_in_t w;
    w.position = 16'($urandom);
    w.sample_time = $urandom;
    case ($urandom_range(0, 9))
      0: w.harmonic = 8'd0;
      1, 2, 3: w.harmonic = 8'($urandom);
      default: w.harmonic = 8'($urandom_range(1, 12));
    endcase
    if ($urandom_range(0, 7) == 0) w.position = 16'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) w.sample_time = $urandom_range(0, 3);
    return w;
  endfunction

  task automatic random_run(input int count, input int hold_at);
    int burst;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      send_word(random_point());
      if (k == hold_at) begin
        drain();
      end else if (--burst == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
      end
    end
    drain();
  endtask

  typedef struct {
    logic [15:0] position;
    logic [31:0] sample_time;
    logic [7:0]  harmonic;
    bit          known;
    logic signed [15:0] want;
  } point_row_t;

  // directed words; only zero-harmonic rows carry a typed-in result
  point_row_t corner_rows[] = '{
    '{16'd0, 32'd0, 8'd0, 1'b1, 16'sd0},
    '{16'hFFFF, 32'hFFFF_FFFF, 8'd0, 1'b1, 16'sd0},
    '{16'd0, 32'd0, 8'd1, 1'b0, 16'sd0},
    '{16'd8192, 32'd0, 8'd1, 1'b0, 16'sd0},
    '{16'd16384, 32'd0, 8'd1, 1'b0, 16'sd0},
    '{16'd24576, 32'd16384, 8'd1, 1'b0, 16'sd0},
    '{16'd8192, 32'd32768, 8'd1, 1'b0, 16'sd0},
    '{16'hFFFF, 32'hFFFF_FFFF, 8'd255, 1'b0, 16'sd0},
    '{16'hFFFF, 32'd0, 8'd1, 1'b0, 16'sd0},
    '{16'd0, 32'hFFFF_FFFF, 8'd1, 1'b0, 16'sd0},
    '{16'd1, 32'd1, 8'd255, 1'b0, 16'sd0},
    '{16'h5555, 32'hAAAA_AAAA, 8'h80, 1'b0, 16'sd0},
    '{16'hAAAA, 32'h5555_5555, 8'h7F, 1'b0, 16'sd0},
    '{16'd4096, 32'd8192, 8'd3, 1'b0, 16'sd0}
  };

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, then the directed table
    apb_check(REG_AMPLITUDE, {16'h0, AMPLITUDE_RST}, 16);
    apb_check(REG_SPATIAL_RATE, SPATIAL_RATE_RST, 32);
    apb_check(REG_TEMPORAL_RATE, TEMPORAL_RATE_RST, 32);
    foreach (corner_rows[r]) begin
      swd_in_t w;
      swd_out_t p;
      w = '{corner_rows[r].position, corner_rows[r].sample_time, corner_rows[r].harmonic};
      p = wave_point(w);
      if (corner_rows[r].known && (p.displacement !== corner_rows[r].want || !p.bad_mode))
        report("directed row", r, -1);
      send_word(w);
    end
    drain();

    // extreme settings, with a write to an unused address
    set_regs(16'h7FFF, 32'hFFFF_FFFF, 32'd1);
    apb_write(2'd3, 32'hDEAD_BEEF);
    foreach (corner_rows[r])
      send_word('{corner_rows[r].position, corner_rows[r].sample_time, corner_rows[r].harmonic});
    drain();
    set_regs(16'h8000, 32'd0, 32'd0);
    random_run(60, -1);
    set_regs(16'h8000, 32'd1, 32'hFFFF_FFFF);
    random_run(100, 50);

    // random settings between runs
    for (int p = 0; p < 5; p++) begin
      set_regs(16'($urandom), $urandom, $urandom);
      random_run(RANDOM_WORDS / 5 - 30, (p == 2) ? 40 : -1);
    end

    drain();
    $display("sent %0d words over nine register settings, %0d results, %0d zero-harmonic",
             words_sent, results_seen, bad_modes_seen);
    if (errors == 0) begin
      $display("standing_wave_displacement: match");
    end else begin
      $display("%0d errors", errors);
      $display("standing_wave_displacement: mismatch");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+src
src/swd_pkg.sv
src/swd_phase.sv
src/swd_cordic.sv
src/swd_scale.sv
src/standing_wave_displacement.sv
tb/standing_wave_displacement_test.sv
